>>> hdl/kwm_pkg.sv
// kwm_pkg: shared types for the k-way sorted merge core.
// Holds the item structs passed between the control module and the top level.
// No dependencies.
package kwm_pkg;

   localparam int VALUE_W = 32;
   localparam int LANE_FIELD_W = 2;

   typedef struct packed {
      logic [LANE_FIELD_W-1:0]  lane;
      logic signed [VALUE_W-1:0] element_value;
      logic                     carries_element;
      logic                     finish;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] merged_value;
      logic [LANE_FIELD_W-1:0]  source_lane;
      logic                     last_of_run;
      logic                     overflow_seen;
   } res_type;

endpackage

>>> hdl/kwm_merge_ctrl.sv
// kwm_merge_ctrl: lane storage memory, per-lane fill and head pointers, and the
// load / scan / emit sequencer of the merge.
// Depends on kwm_pkg for the item structs.
module kwm_merge_ctrl #(
   parameter int LANES = 4,
   parameter int LANE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  kwm_pkg::req_type req_item,
   input  logic             req_take,
   output logic             busy,
   output kwm_pkg::res_type res_item,
   output logic             res_valid,
   input  logic             res_take
);

   localparam int ENTRIES = LANES * LANE_DEPTH;
   localparam int AW = $clog2(ENTRIES);
   localparam int LW = $clog2(LANES);
   localparam int FW = $clog2(LANE_DEPTH + 1);
   localparam int TW = $clog2(ENTRIES + 1);
   localparam int SW = $clog2(LANES + 1);

   typedef enum logic [1:0] {S_LOAD, S_SCAN, S_EMIT} state_type;

   state_type state_ff;

   logic [kwm_pkg::VALUE_W-1:0] lane_store_ff [ENTRIES];
   logic [kwm_pkg::VALUE_W-1:0] rd_data_ff;

   logic [FW-1:0] fill_ff [LANES];
   logic [FW-1:0] head_ff [LANES];
   logic [TW-1:0] total_ff;
   logic          ovf_ff;
   logic [SW-1:0] scan_ff;
   logic          probe_ff;
   logic [LW-1:0] probe_lane_ff;
   logic          best_found_ff;
   logic [kwm_pkg::VALUE_W-1:0] best_val_ff;
   logic [LW-1:0] best_lane_ff;

   logic [LW-1:0] load_lane;
   logic          lane_ok;
   logic [LW-1:0] scan_lane;
   logic [LW-1:0] sel_lane;
   logic [FW-1:0] fill_sel;
   logic [FW-1:0] head_sel;
   logic          has_room;
   logic          lane_live;
   logic          do_store;
   logic          do_drop;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [TW-1:0] total_plus;
   logic          take_new;

   assign load_lane = LW'(req_item.lane);
   assign lane_ok   = int'(req_item.lane) < LANES;
   assign scan_lane = scan_ff[LW-1:0];

   always_comb begin
      unique case (state_ff)
         S_LOAD:  sel_lane = load_lane;
         S_SCAN:  sel_lane = scan_lane;
         S_EMIT:  sel_lane = best_lane_ff;
         default: sel_lane = load_lane;
      endcase
   end

   assign fill_sel  = fill_ff[sel_lane];
   assign head_sel  = head_ff[sel_lane];
   assign has_room  = fill_sel < FW'(LANE_DEPTH);
   assign lane_live = head_sel < fill_sel;

   assign do_store = req_take && req_item.carries_element && lane_ok && has_room;
   assign do_drop  = req_take && req_item.carries_element && lane_ok && !has_room;

   assign wr_en   = do_store;
   assign wr_addr = AW'(int'(load_lane) * LANE_DEPTH + int'(fill_sel));

   // at most one head read per live lane, issued in lane order
   assign rd_en   = (state_ff == S_SCAN) && (scan_ff != SW'(LANES)) && lane_live;
   assign rd_addr = AW'(int'(scan_lane) * LANE_DEPTH + int'(head_sel));

   assign total_plus = total_ff + TW'(do_store);

   // strict compare keeps the lower lane on a tie
   assign take_new = probe_ff &&
                     (!best_found_ff || ($signed(rd_data_ff) < $signed(best_val_ff)));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lane_store_ff[wr_addr] <= req_item.element_value;
      end
      if (rd_en) begin
         rd_data_ff <= lane_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         scan_ff       <= '0;
         probe_ff      <= 1'b0;
         best_found_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         probe_ff      <= rd_en;
         probe_lane_ff <= scan_lane;
         if (take_new) begin
            best_found_ff <= 1'b1;
            best_val_ff   <= rd_data_ff;
            best_lane_ff  <= probe_lane_ff;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (do_store) begin
                  fill_ff[load_lane] <= fill_sel + 1'b1;
               end
               total_ff <= total_plus;
               if (do_drop) begin
                  ovf_ff <= 1'b1;
               end
               if (req_take && req_item.finish) begin
                  if (total_plus == '0) begin
                     ovf_ff <= 1'b0;
                  end else begin
                     state_ff      <= S_SCAN;
                     scan_ff       <= '0;
                     best_found_ff <= 1'b0;
                  end
               end
            end
            S_SCAN: begin
               if (scan_ff != SW'(LANES)) begin
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  // last probe is compared on this edge
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (res_take) begin
                  total_ff <= total_ff - 1'b1;
                  if (total_ff == TW'(1)) begin
                     for (int i = 0; i < LANES; i++) begin
                        fill_ff[i] <= '0;
                        head_ff[i] <= '0;
                     end
                     ovf_ff   <= 1'b0;
                     state_ff <= S_LOAD;
                  end else begin
                     head_ff[best_lane_ff] <= head_sel + 1'b1;
                     state_ff      <= S_SCAN;
                     scan_ff       <= '0;
                     best_found_ff <= 1'b0;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign busy      = state_ff != S_LOAD;
   assign res_valid = state_ff == S_EMIT;

   always_comb begin
      res_item.merged_value  = best_val_ff;
      res_item.source_lane   = kwm_pkg::LANE_FIELD_W'(best_lane_ff);
      res_item.last_of_run   = total_ff == TW'(1);
      res_item.overflow_seen = ovf_ff;
   end

endmodule

>>> hdl/k_way_sorted_merge_core.sv
// k_way_sorted_merge_core: top level of the k-way sorted merge.
// Instantiates kwm_merge_ctrl and holds the output register; uses kwm_pkg.
//
//   channel  ports   direction  content
//   req      req_*   in         lane, element_value, carries_element, finish
//   rsp      rsp_*   out        merged_value, source_lane, last_of_run, overflow_seen
//
// loading takes one item per cycle while req_stall is low; an item with finish
// starts the merge if any element is stored, and req_stall stays high until the
// last result has left the merge sequencer. each result takes one memory read per
// live lane head, then the final compare and the hand-off to the output register.
// reset is synchronous, holds req_stall high and empties all lanes; the element
// memory is not cleared.
// rsp_stall holds the output register, while the next result is already scanned.
module k_way_sorted_merge_core #(
   parameter int LANES = 4,
   parameter int LANE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_lane,
   input  logic signed [31:0] req_element_value,
   input  logic        req_carries_element,
   input  logic        req_finish,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_merged_value,
   output logic [1:0]  rsp_source_lane,
   output logic        rsp_last_of_run,
   output logic        rsp_overflow_seen
);

   kwm_pkg::req_type req_item;
   kwm_pkg::res_type res_item;
   kwm_pkg::res_type out_item_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic             busy;
   logic             req_take;
   logic             res_valid;
   logic             res_take;

   always_comb begin
      req_item.lane            = req_lane;
      req_item.element_value   = req_element_value;
      req_item.carries_element = req_carries_element;
      req_item.finish          = req_finish;
   end

   assign req_stall = busy || reset;
   assign req_take  = req_valid && !req_stall;

   kwm_merge_ctrl #(
      .LANES      (LANES),
      .LANE_DEPTH (LANE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .req_take  (req_take),
      .busy      (busy),
      .res_item  (res_item),
      .res_valid (res_valid),
      .res_take  (res_take)
   );

   // output register loads when empty or being drained
   assign res_take     = res_valid && (!out_valid_ff || !rsp_stall);
   assign out_valid_in = res_take || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         out_item_ff <= res_item;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_merged_value  = out_item_ff.merged_value;
   assign rsp_source_lane   = out_item_ff.source_lane;
   assign rsp_last_of_run   = out_item_ff.last_of_run;
   assign rsp_overflow_seen = out_item_ff.overflow_seen;

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for k_way_sorted_merge_core.
// loads sorted and unsorted runs with random gaps and stalls, predicts the merged order
// in a scoreboard class and checks every result; needs kwm_pkg and the core rtl.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANES = 4;
   localparam int LANE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TARGET_ITEMS = 150;
   localparam int DRAIN_CYCLES = 4 * (LANES + 2);

   class merged_order_board;
      logic signed [kwm_pkg::VALUE_W-1:0] lane_data[LANES][LANE_DEPTH];
      int unsigned lane_count[LANES];
      bit dropped;
      kwm_pkg::res_type merged_due[$];
      int mismatches;

      function new();
         foreach (lane_count[i]) lane_count[i] = 0;
         dropped = 1'b0;
         mismatches = 0;
      endfunction

      function int pending();
         return merged_due.size();
      endfunction

      // store or drop the element, then on finish queue the whole merged order
      function void accept_request(logic [1:0] lane, logic signed [31:0] value,
                                   logic carries, logic fin);
         int unsigned head[LANES];
         int unsigned total;
         int best;
         kwm_pkg::res_type r;
         if (carries) begin
            if (lane_count[lane] < LANE_DEPTH) begin
               lane_data[lane][lane_count[lane]] = value;
               lane_count[lane]++;
            end else begin
               dropped = 1'b1;
            end
         end
         if (!fin) return;
         total = 0;
         foreach (head[i]) begin
            head[i] = 0;
            total += lane_count[i];
         end
         for (int n = 0; n < total; n++) begin
            best = -1;
            // strict compare keeps ties on the lower lane
            for (int i = 0; i < LANES; i++) begin
               if (head[i] < lane_count[i] &&
                   (best < 0 || lane_data[i][head[i]] < lane_data[best][head[best]]))
                  best = i;
            end
            r.merged_value = lane_data[best][head[best]];
            r.source_lane = 2'(best);
            r.last_of_run = (n == total - 1);
            r.overflow_seen = dropped;
            merged_due.insert(merged_due.size(), r);
            head[best]++;
         end
         foreach (lane_count[i]) lane_count[i] = 0;
         dropped = 1'b0;
      endfunction

      function void check_merged(kwm_pkg::res_type got);
         kwm_pkg::res_type want;
         if (merged_due.size() == 0) begin
            $display("%0t: unexpected item, expected none, got value %0d lane %0d",
                     $time, got.merged_value, got.source_lane);
            mismatches++;
            return;
         end
         want = merged_due.pop_front();
         if (got.merged_value !== want.merged_value) begin
            $display("%0t: merged_value expected %0d got %0d",
                     $time, want.merged_value, got.merged_value);
            mismatches++;
         end
         if (got.source_lane !== want.source_lane) begin
            $display("%0t: source_lane expected %0d got %0d",
                     $time, want.source_lane, got.source_lane);
            mismatches++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b got %0b",
                     $time, want.last_of_run, got.last_of_run);
            mismatches++;
         end
         if (got.overflow_seen !== want.overflow_seen) begin
            $display("%0t: overflow_seen expected %0b got %0b",
                     $time, want.overflow_seen, got.overflow_seen);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_lane;
   logic signed [31:0] req_element_value;
   logic req_carries_element;
   logic req_finish;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_merged_value;
   logic [1:0] rsp_source_lane;
   logic rsp_last_of_run;
   logic rsp_overflow_seen;

   merged_order_board board = new();
   bit calm = 1'b0;
   int items_sent = 0;
   int cycle_count = 0;
   int stall_hold;
   int set_kind;

   k_way_sorted_merge_core #(
      .LANES(LANES),
      .LANE_DEPTH(LANE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_lane(req_lane),
      .req_element_value(req_element_value),
      .req_carries_element(req_carries_element),
      .req_finish(req_finish),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_merged_value(rsp_merged_value),
      .rsp_source_lane(rsp_source_lane),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_overflow_seen(rsp_overflow_seen)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_merged('{merged_value: rsp_merged_value,
                              source_lane: rsp_source_lane,
                              last_of_run: rsp_last_of_run,
                              overflow_seen: rsp_overflow_seen});
   end

   // result side: random stall before each item, none while calm
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         stall_hold = calm ? 0 : $urandom_range(0, 6);
         if (stall_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   // called and left at a falling edge; valid stays high on back-to-back items
   task automatic send_item(logic [1:0] lane, logic signed [31:0] value,
                            logic carries, logic fin);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_lane <= lane;
      req_element_value <= value;
      req_carries_element <= carries;
      req_finish <= fin;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.accept_request(lane, value, carries, fin);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_expected();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0)
         send_item(2'($urandom_range(0, 3)), $urandom(), 1'b0, 1'b0);
   endtask

   // sorted runs per lane, loaded interleaved; now and then a lane overfills
   task automatic send_merge_set();
      int runs[LANES][$];
      int len;
      int remaining;
      int pick;
      int v;
      bit narrow;
      bit finish_rides;
      bit finished;
      narrow = ($urandom_range(0, 1) == 0);
      finish_rides = ($urandom_range(0, 1) == 0);
      finished = 1'b0;
      remaining = 0;
      for (int i = 0; i < LANES; i++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(LANE_DEPTH, LANE_DEPTH + 3)
                                           : $urandom_range(0, 4);
         repeat (len) begin
            v = narrow ? $urandom_range(0, 8) - 4 : $urandom();
            runs[i].insert(runs[i].size(), v);
         end
         runs[i].sort();
         remaining += len;
      end
      while (remaining > 0) begin
         do pick = $urandom_range(0, LANES - 1); while (runs[pick].size() == 0);
         v = runs[pick].pop_front();
         remaining--;
         maybe_noise();
         finished = finish_rides && remaining == 0;
         send_item(2'(pick), v, 1'b1, finished);
      end
      if (!finished)
         send_item(2'($urandom_range(0, 3)), $urandom(), 1'b0, 1'b1);
   endtask

   // unsorted values in random lanes
   task automatic send_loose_set();
      int len;
      len = $urandom_range(0, 6);
      repeat (len) begin
         maybe_noise();
         send_item(2'($urandom_range(0, 3)), $urandom(), 1'b1, 1'b0);
      end
      send_item(2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_lane = '0;
      req_element_value = '0;
      req_carries_element = 1'b0;
      req_finish = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // finish with nothing stored
      send_item(2'd1, 32'sd0, 1'b0, 1'b1);
      // extremes and ties across and within lanes, last load rides with finish
      send_item(2'd0, 32'sh8000_0000, 1'b1, 1'b0);
      send_item(2'd3, 32'sh7fff_ffff, 1'b1, 1'b0);
      send_item(2'd1, 32'sd0, 1'b1, 1'b0);
      send_item(2'd2, -32'sd1, 1'b1, 1'b0);
      send_item(2'd1, 32'sd0, 1'b1, 1'b0);
      send_item(2'd2, 32'sd0, 1'b1, 1'b0);
      send_item(2'd0, 32'sd5, 1'b1, 1'b1);
      // fill one lane, then a load into the full lane together with finish
      for (int i = 0; i < LANE_DEPTH; i++)
         send_item(2'd2, 32'(i * 3 - 20), 1'b1, 1'b0);
      send_item(2'd2, 32'sd100, 1'b1, 1'b1);
      drain_expected();

      while (items_sent < TARGET_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         set_kind = $urandom_range(0, 9);
         if (set_kind < 8)
            send_merge_set();
         else
            send_loose_set();
         if ($urandom_range(0, 7) == 0)
            drain_expected();
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
hdl/kwm_pkg.sv
hdl/kwm_merge_ctrl.sv
hdl/k_way_sorted_merge_core.sv
sim/testbench.sv
